FILE: sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/png_unf_pkg.sv
// shared types and constants for the png scanline unfilter
`timescale 1ns / 1ps

package png_unf_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd1;
  localparam int CFG_DATA_W = 15;

  localparam logic [14:0] ROW_BYTES_RESET = 15'd3;
  localparam logic [2:0]  BPP_RESET       = 3'd3;

  // filter type codes as they appear in the byte stream
  localparam logic [7:0] FT_NONE  = 8'd0;
  localparam logic [7:0] FT_SUB   = 8'd1;
  localparam logic [7:0] FT_UP    = 8'd2;
  localparam logic [7:0] FT_AVG   = 8'd3;
  localparam logic [7:0] FT_PAETH = 8'd4;

  // internal operation codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_UP    = 3'd2;
  localparam logic [2:0] OP_AVG   = 3'd3;
  localparam logic [2:0] OP_PAETH = 3'd4;

  // widest column and history index over the supported parameter range
  localparam int COL_MAX_W  = 16;
  localparam int HIST_IDX_W = 3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]            raw;
    logic [COL_MAX_W-1:0]  col;
    logic [2:0]            op;
    logic                  unknown;
    logic                  first_row;
    logic                  row_end;
    logic                  has_left;
    logic [HIST_IDX_W-1:0] hist_idx;
  } unf_item_t;

endpackage

FILE: sv/png_unf_ifs.sv
// request channel interfaces for filtered bytes and reconstructed bytes
`timescale 1ns / 1ps

interface png_unf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       start_image;

  modport source (output valid, output raw_byte, output start_image, input ready);
  modport sink (input valid, input raw_byte, input start_image, output ready);
endinterface

interface png_unf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       unknown_filter;

  modport source (output valid, output pixel_byte, output row_end,
                  output unknown_filter, input ready);
  modport sink (input valid, input pixel_byte, input row_end,
                input unknown_filter, output ready);
endinterface

FILE: sv/png_scanline_unfilter_top.sv
// top level of the png scanline unfilter
`timescale 1ns / 1ps

// channel    dir   payload                                    handshake
// filtered   in    raw_byte[7:0], start_image                 valid / ready
// pixels     out   pixel_byte[7:0], row_end, unknown_filter   valid / ready
// cfg        in    cfg_index, cfg_data[14:0]                  cfg_we only
//
// one request per cycle sustained while pixels stays ready; filter bytes
// produce no output; a sample byte reaches pixels through the queue entry,
// the predictor stage and the output register; the predictor stage's single
// line-store read per request sets the rate
// rst is synchronous; the line store needs no clearing pass after reset
// filtered.ready drops only while the two-entry queue is full, so a stalled
// pixels sink backs up through the output register, the predictor stage and
// the queue before the input side sees it

module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [png_unf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [png_unf_pkg::CFG_DATA_W-1:0] cfg_data,
  png_unf_in_if.sink                        filtered,
  png_unf_out_if.source                     pixels
);
  import png_unf_pkg::*;

  // front to queue
  logic      push_valid;
  logic      push_ready;
  unf_item_t push_item;

  // queue to back
  logic      pop_valid;
  logic      pop_ready;
  unf_item_t pop_item;

  // front: tracks filter bytes and columns, classifies each sample
  png_unf_front #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .filtered   (filtered),
    .item_valid (push_valid),
    .item       (push_item),
    .item_ready (push_ready)
  );

  // decouples the two halves so either can stall alone
  png_unf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // back: reads the row above, predicts, adds, writes back and outputs
  png_unf_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (pop_valid),
    .head       (pop_item),
    .head_ready (pop_ready),
    .pixels     (pixels)
  );

endmodule

FILE: sv/png_unf_queue.sv
// two-entry request queue between the front and the back
`timescale 1ns / 1ps
`include "assert_macros.svh"

module png_unf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  png_unf_pkg::unf_item_t push_item,
  output logic                  push_ready,
  output logic                  pop_valid,
  output png_unf_pkg::unf_item_t pop_item,
  input  logic                  pop_ready
);
  import png_unf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  unf_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_pop_drains, clk, rst, pop_fire && !push_fire, count == $past(count) - 1'b1)
  `ASSERT_NEXT(a_push_fills, clk, rst, push_fire && !pop_fire, count == $past(count) + 1'b1)

endmodule

FILE: sv/png_unf_front.sv
// front end: configuration, row tracking and filter classification
`timescale 1ns / 1ps

module png_unf_front #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [png_unf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [png_unf_pkg::CFG_DATA_W-1:0]       cfg_data,
  png_unf_in_if.sink                              filtered,
  output logic                                    item_valid,
  output png_unf_pkg::unf_item_t                   item,
  input  logic                                    item_ready
);
  import png_unf_pkg::*;

  localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CMP_W  = (COL_W + 1 > 15) ? COL_W + 1 : 15;
  localparam int PB_W   = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int BPP_W  = (PB_W > 3) ? PB_W : 3;

  logic [14:0]      row_bytes;
  logic [2:0]       bytes_per_pixel;
  logic [COL_W-1:0] column_count;
  logic [2:0]       row_op;
  logic             row_unknown;
  logic             await_filter;
  logic             first_row;

  logic [CMP_W-1:0] rb_ext;
  logic [CMP_W-1:0] len_eff;
  logic [BPP_W-1:0] bp_ext;
  logic [BPP_W-1:0] bpp_eff;
  logic [CMP_W-1:0] col_ext;
  logic             at_end;
  logic             accept;
  logic             header;
  logic [2:0]       op_new;
  logic             unknown_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= ROW_BYTES_RESET;
      bytes_per_pixel <= BPP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_BYTES:       row_bytes       <= cfg_data[14:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp the register values into their working range
  always_comb begin
    rb_ext = CMP_W'(row_bytes);
    if (rb_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (rb_ext > CMP_W'(MAX_ROW_BYTES)) begin
      len_eff = CMP_W'(MAX_ROW_BYTES);
    end else begin
      len_eff = rb_ext;
    end
    bp_ext = BPP_W'(bytes_per_pixel);
    if (bp_ext == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bp_ext > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bp_ext;
    end
  end

  always_comb begin
    case (filtered.raw_byte)
      FT_NONE:  begin op_new = OP_NONE;  unknown_new = 1'b0; end
      FT_SUB:   begin op_new = OP_SUB;   unknown_new = 1'b0; end
      FT_UP:    begin op_new = OP_UP;    unknown_new = 1'b0; end
      FT_AVG:   begin op_new = OP_AVG;   unknown_new = 1'b0; end
      FT_PAETH: begin op_new = OP_PAETH; unknown_new = 1'b0; end
      default:  begin op_new = OP_NONE;  unknown_new = 1'b1; end
    endcase
  end

  assign col_ext = CMP_W'(column_count);
  assign at_end  = (col_ext + 1'b1) >= len_eff;

  assign filtered.ready = item_ready;
  assign accept = filtered.valid && filtered.ready;
  assign header = filtered.start_image || await_filter;

  assign item_valid = accept && !header;

  always_comb begin
    item.raw       = filtered.raw_byte;
    item.col       = COL_MAX_W'(column_count);
    item.op        = row_op;
    item.unknown   = row_unknown;
    item.first_row = first_row;
    item.row_end   = at_end;
    item.has_left  = col_ext >= CMP_W'(bpp_eff);
    item.hist_idx  = HIST_IDX_W'(bpp_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_op       <= OP_NONE;
      row_unknown  <= 1'b0;
      await_filter <= 1'b1;
      first_row    <= 1'b1;
    end else if (accept) begin
      if (header) begin
        row_op       <= op_new;
        row_unknown  <= unknown_new;
        column_count <= '0;
        await_filter <= 1'b0;
        if (filtered.start_image) begin
          first_row <= 1'b1;
        end
      end else if (at_end) begin
        column_count <= '0;
        await_filter <= 1'b1;
        first_row    <= 1'b0;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

FILE: sv/png_unf_back.sv
// back end: above-row store, predictor and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module png_unf_back #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  png_unf_pkg::unf_item_t head,
  output logic                  head_ready,
  png_unf_out_if.source         pixels
);
  import png_unf_pkg::*;

  localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int HW     = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0]        store [MAX_ROW_BYTES];
  logic [7:0]        above_q;
  logic              byp;
  logic [7:0]        byp_data;

  logic              sa_valid;
  unf_item_t         sa_item;
  logic [7:0]        left_hist [MAX_PIXEL_BYTES];
  logic [7:0]        up_hist [MAX_PIXEL_BYTES];

  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_end;
  logic              out_unk;

  logic              sa_adv;
  logic              pop_fire;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [HW-1:0]     idx;
  logic [7:0]        above;
  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        ab_sum;
  logic [7:0]        pred;
  logic [7:0]        val;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic [8:0] s;
    logic [8:0] c2;
    logic [7:0] da;
    logic [7:0] db;
    logic [8:0] dc;
    s  = {1'b0, pa_a} + {1'b0, pa_b};
    c2 = {pa_c, 1'b0};
    da = (pa_b > pa_c) ? pa_b - pa_c : pa_c - pa_b;
    db = (pa_a > pa_c) ? pa_a - pa_c : pa_c - pa_a;
    dc = (s > c2) ? s - c2 : c2 - s;
    if ({1'b0, da} <= {1'b0, db} && {1'b0, da} <= dc) begin
      paeth = pa_a;
    end else if ({1'b0, db} <= dc) begin
      paeth = pa_b;
    end else begin
      paeth = pa_c;
    end
  endfunction

  assign sa_adv     = sa_valid && (!out_valid || pixels.ready);
  assign head_ready = !sa_valid || sa_adv;
  assign pop_fire   = head_valid && head_ready;
  assign rd_addr    = head.col[ADDR_W-1:0];
  assign wr_addr    = sa_item.col[ADDR_W-1:0];

  // line store, read when a request enters the predictor stage
  always_ff @(posedge clk) begin
    if (sa_adv) begin
      store[wr_addr] <= val;
    end
    if (pop_fire) begin
      above_q <= store[rd_addr];
    end
  end

  // forward a write that lands on the column being read
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      byp      <= sa_adv && (wr_addr == rd_addr);
      byp_data <= val;
    end
  end

  assign above  = byp ? byp_data : above_q;
  assign idx    = sa_item.hist_idx[HW-1:0];
  assign a      = sa_item.has_left ? left_hist[idx] : 8'd0;
  assign b      = sa_item.first_row ? 8'd0 : above;
  assign c      = (!sa_item.first_row && sa_item.has_left) ? up_hist[idx] : 8'd0;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (sa_item.op)
      OP_SUB:   pred = a;
      OP_UP:    pred = b;
      OP_AVG:   pred = ab_sum[8:1];
      OP_PAETH: pred = paeth(a, b, c);
      default:  pred = 8'd0;
    endcase
  end

  assign val = sa_item.raw + pred;

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      sa_item <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (head_ready) begin
      sa_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i] <= 8'd0;
        up_hist[i]   <= 8'd0;
      end
    end else if (sa_adv) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i] <= left_hist[i-1];
        up_hist[i]   <= up_hist[i-1];
      end
      left_hist[0] <= val;
      up_hist[0]   <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_adv) begin
      out_byte <= val;
      out_end  <= sa_item.row_end;
      out_unk  <= sa_item.unknown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sa_adv) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pixels.valid          = out_valid;
  assign pixels.pixel_byte     = out_byte;
  assign pixels.row_end        = out_end;
  assign pixels.unknown_filter = out_unk;

  `ASSERT_NEXT(a_adv_fills_out, clk, rst, sa_adv, out_valid)
  `ASSERT_IMPLY(a_empty_stage_ready, clk, rst, !sa_valid, head_ready)
  `ASSERT_NEXT(a_pop_fills_stage, clk, rst, pop_fire, sa_valid)

endmodule

FILE: tb/png_scanline_unfilter_top_tb.sv
// self-checking testbench for the png scanline unfilter top level
`timescale 1ns / 1ps

module png_scanline_unfilter_top_tb;
  import png_unf_pkg::*;

  localparam int ROW_CAP   = 16384;
  localparam int PIX_CAP   = 4;
  // cycles with no request moving on either side before the run is given up
  localparam int HANG_LIMIT = 4000;

  // one filtered-byte request and one reconstructed-byte request
  typedef struct packed {
    logic [7:0] raw;
    logic       start;
  } filt_req_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad_filter;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  png_unf_in_if  filtered_ch ();
  png_unf_out_if pixels_ch ();

  png_scanline_unfilter_top #(
    .MAX_ROW_BYTES  (ROW_CAP),
    .MAX_PIXEL_BYTES(PIX_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .filtered (filtered_ch),
    .pixels   (pixels_ch)
  );

  // pending filtered bytes, filled by the sequence, drained by the driver
  filt_req_t filtered_stream[$];
  // reconstructed bytes the block still owes us, oldest first
  pixel_t    owed_pixels[$];

  int mismatch_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hang_cycles = 0;

  // register values as last written, shared by predictor and sequence
  logic [14:0] cfg_row_bytes = ROW_BYTES_RESET;
  logic [2:0]  cfg_bpp = BPP_RESET;

  // predictor state, starts out at its reset values
  logic [7:0] above_row [ROW_CAP];
  logic [7:0] left_hist [PIX_CAP] = '{default: 8'h00};
  logic [7:0] upleft_hist [PIX_CAP] = '{default: 8'h00};
  int         col_cnt = 0;
  logic [7:0] cur_filter = FT_NONE;
  bit         want_filter = 1'b1;
  bit         image_top = 1'b1;

  // sequence-side tracking, used only to keep every store read on written data
  int gen_col = 0;
  int gen_fill = 0;
  bit gen_await = 1'b1;
  bit gen_first = 1'b1;

  initial forever #6 clk = ~clk;

  // out-of-range register values fold into the legal range
  function automatic int eff_len(input logic [14:0] v);
    if (v == 0) return 1;
    if (v > ROW_CAP) return ROW_CAP;
    return int'(v);
  endfunction

  function automatic int eff_bpp(input logic [2:0] v);
    if (v == 0) return 1;
    if (v > PIX_CAP) return PIX_CAP;
    return int'(v);
  endfunction

  // reconstruct one accepted request and queue the byte it should produce
  task automatic reconstruct_byte(input logic [7:0] raw, input logic start);
    int len, bpp, col, ia, ib, ic, pa, pb, pc;
    logic [7:0] a, b, c, pred, val;
    logic at_end;
    pixel_t exp_px;
    len = eff_len(cfg_row_bytes);
    bpp = eff_bpp(cfg_bpp);
    if (start) begin
      image_top = 1'b1;
      want_filter = 1'b1;
    end
    if (want_filter) begin
      // filter type byte: latch it, nothing comes out
      cur_filter = raw;
      col_cnt = 0;
      want_filter = 1'b0;
    end else begin
      col = (col_cnt >= ROW_CAP) ? ROW_CAP - 1 : col_cnt;
      a = (col >= bpp) ? left_hist[bpp-1] : 8'h00;
      b = image_top ? 8'h00 : above_row[col];
      c = (!image_top && col >= bpp) ? upleft_hist[bpp-1] : 8'h00;
      ia = int'(a);
      ib = int'(b);
      ic = int'(c);
      case (cur_filter)
        FT_NONE:  val = raw;
        FT_SUB:   val = raw + a;
        FT_UP:    val = raw + b;
        FT_AVG:   val = raw + 8'((ia + ib) >> 1);
        FT_PAETH: begin
          // distances of p = a + b - c to a, b and c, ties go a, then b
          pa = (ib > ic) ? ib - ic : ic - ib;
          pb = (ia > ic) ? ia - ic : ic - ia;
          pc = (ia + ib > 2 * ic) ? ia + ib - 2 * ic : 2 * ic - ia - ib;
          if (pa <= pb && pa <= pc) pred = a;
          else if (pb <= pc) pred = b;
          else pred = c;
          val = raw + pred;
        end
        default:  val = raw;
      endcase
      for (int k = PIX_CAP - 1; k > 0; k--) begin
        left_hist[k] = left_hist[k-1];
        upleft_hist[k] = upleft_hist[k-1];
      end
      left_hist[0] = val;
      upleft_hist[0] = b;
      above_row[col] = val;
      at_end = (col + 1 >= len);
      if (at_end) begin
        want_filter = 1'b1;
        image_top = 1'b0;
        col_cnt = 0;
      end else begin
        col_cnt = col + 1;
      end
      exp_px.pixel = val;
      exp_px.row_end = at_end;
      exp_px.bad_filter = (cur_filter > FT_PAETH);
      owed_pixels = {owed_pixels, exp_px};
    end
  endtask

  // queue one request; a sample that would read a never-written line store
  // entry is turned into the filter byte of a new image instead
  function automatic void queue_byte(input logic [7:0] raw, input logic start);
    filt_req_t req;
    if (!start && !gen_await && !gen_first && gen_col >= gen_fill) start = 1'b1;
    req.raw = raw;
    req.start = start;
    filtered_stream = {filtered_stream, req};
    if (start) begin
      gen_first = 1'b1;
      gen_await = 1'b1;
    end
    if (gen_await) begin
      gen_await = 1'b0;
      gen_col = 0;
    end else begin
      if (gen_col + 1 > gen_fill) gen_fill = gen_col + 1;
      if (gen_col + 1 >= eff_len(cfg_row_bytes)) begin
        gen_await = 1'b1;
        gen_first = 1'b0;
        gen_col = 0;
      end else begin
        gen_col++;
      end
    end
  endfunction

  // sample bytes lean toward the ends of the range now and then
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_row(input logic [7:0] filt, input logic start, input int n);
    queue_byte(filt, start);
    repeat (n) queue_byte(pick_sample(), 1'b0);
  endfunction

  // register write, only ever issued with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_ROW_BYTES) cfg_row_bytes = data;
    else cfg_bpp = data[2:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every queued request went in and every byte came out,
  // then give a filter byte still in the pipe time to settle
  task automatic drain();
    while (filtered_stream.size() != 0 || filtered_ch.valid || owed_pixels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver: presents queued requests, skipping cycles at the sender idle rate
  always @(posedge clk) begin : drive_filtered
    filt_req_t nxt;
    if (rst) begin
      filtered_ch.valid <= 1'b0;
      filtered_ch.raw_byte <= 8'h00;
      filtered_ch.start_image <= 1'b0;
    end else begin
      if (filtered_ch.valid && filtered_ch.ready)
        reconstruct_byte(filtered_ch.raw_byte, filtered_ch.start_image);
      // next request only once the current one has gone in
      if (!filtered_ch.valid || filtered_ch.ready) begin
        if (filtered_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = filtered_stream.pop_front();
          filtered_ch.valid <= 1'b1;
          filtered_ch.raw_byte <= nxt.raw;
          filtered_ch.start_image <= nxt.start;
        end else begin
          filtered_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every accepted pixel against the oldest owed byte
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst) begin
      pixels_ch.ready <= 1'b0;
    end else begin
      if (pixels_ch.valid && pixels_ch.ready) begin
        if (owed_pixels.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected pixel, expected none, got %02h row_end %0b unknown %0b",
                   $time, pixels_ch.pixel_byte, pixels_ch.row_end, pixels_ch.unknown_filter);
        end else begin
          want = owed_pixels.pop_front();
          if (pixels_ch.pixel_byte !== want.pixel) begin
            mismatch_cnt++;
            $display("%0t: pixel_byte mismatch, expected %02h, got %02h",
                     $time, want.pixel, pixels_ch.pixel_byte);
          end
          if (pixels_ch.row_end !== want.row_end) begin
            mismatch_cnt++;
            $display("%0t: row_end mismatch, expected %0b, got %0b",
                     $time, want.row_end, pixels_ch.row_end);
          end
          if (pixels_ch.unknown_filter !== want.bad_filter) begin
            mismatch_cnt++;
            $display("%0t: unknown_filter mismatch, expected %0b, got %0b",
                     $time, want.bad_filter, pixels_ch.unknown_filter);
          end
        end
      end
      pixels_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: too long with no request moving on either side is a hang
  always @(posedge clk) begin : hang_watch
    if (rst || (filtered_ch.valid && filtered_ch.ready) || (pixels_ch.valid && pixels_ch.ready))
      hang_cycles <= 0;
    else
      hang_cycles <= hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sequence
  initial begin : stimulus
    int n, len_e, nb, r;
    logic [7:0] filt;
    logic st;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // sender idles a quarter of the time, receiver stalls two thirds
    send_idle_pct = 24;
    recv_stall_pct = 66;

    // directed: reset geometry, first row straight after reset, then an up row
    queue_row(FT_NONE, 1'b1, 0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_row(FT_UP, 1'b0, 0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    drain();

    // directed: 4-byte rows of 2-byte pixels so left and upper-left neighbors count
    write_reg(REG_ROW_BYTES, 15'd4);
    write_reg(REG_BYTES_PER_PIXEL, 15'd2);
    queue_row(FT_SUB, 1'b1, 0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_row(FT_AVG, 1'b0, 0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_row(FT_PAETH, 1'b0, 0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h10, 1'b0);
    // unknown filter type passes bytes through, then a new image cuts the row
    queue_row(8'd5, 1'b0, 2);
    queue_row(8'hFF, 1'b1, 2);
    drain();

    // both registers written past their legal range, row left open part way
    write_reg(REG_ROW_BYTES, 15'h7FFF);
    write_reg(REG_BYTES_PER_PIXEL, 15'h7FFF);
    queue_row(FT_PAETH, 1'b1, 100);
    // pause mid-row, then shrink the row: the next sample ends it
    drain();
    write_reg(REG_ROW_BYTES, 15'd60);
    queue_byte(pick_sample(), 1'b0);
    queue_row(FT_SUB, 1'b0, 60);
    drain();

    // random phases: mostly well-formed rows with random content, some noise
    // and cut rows; a phase can end mid-row so the new geometry lands there
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 66;
        recv_stall_pct = 24;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 10) write_reg(REG_ROW_BYTES, 15'd0);
      else if (r < 20) write_reg(REG_ROW_BYTES, 15'd1);
      else if (r < 26) write_reg(REG_ROW_BYTES, 15'd16384);
      else write_reg(REG_ROW_BYTES, 15'($urandom_range(2, 24)));
      write_reg(REG_BYTES_PER_PIXEL, 15'($urandom_range(0, 7)) | (15'($urandom) & 15'h7FF8));
      n = 0;
      len_e = eff_len(cfg_row_bytes);
      if (!gen_await && len_e <= 64 && $urandom_range(1) == 1) begin
        while (!gen_await) begin
          queue_byte(pick_sample(), 1'b0);
          n++;
        end
      end
      while (n < 46) begin
        r = $urandom_range(99);
        if (r < 6) begin
          queue_byte(8'($urandom), ($urandom_range(99) < 30));
          n++;
        end else begin
          filt = ($urandom_range(99) < 88) ? 8'($urandom_range(0, 4))
                                           : 8'($urandom_range(5, 255));
          // a row that was cut short needs a new image to realign
          st = gen_await ? ($urandom_range(99) < 20) : 1'b1;
          if (len_e > 64) nb = $urandom_range(1, 40);
          else if ($urandom_range(99) < 12) nb = $urandom_range(0, len_e - 1);
          else nb = len_e;
          queue_row(filt, st, nb);
          n += nb + 1;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && owed_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: png_scanline_unfilter_top.f
+incdir+sv
sv/png_unf_pkg.sv
sv/png_unf_ifs.sv
sv/png_unf_queue.sv
sv/png_unf_front.sv
sv/png_unf_back.sv
sv/png_scanline_unfilter_top.sv
tb/png_scanline_unfilter_top_tb.sv
